// ===== src/brb_pkg.sv =====
// shared constants and types for the bayer 2x2 binning block
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

  // line store geometry
  localparam int MAX_WIDTH  = 512;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int COLC_W     = COL_W + 1;
  localparam int BANK_DEPTH = MAX_WIDTH / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  // frame geometry
  localparam int MAX_ROWS = 1024;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int ROWC_W   = ROW_W + 1;

  // beat fields
  localparam int PIXEL_W    = 16;
  localparam int SAMPLE_W   = 8;
  localparam int SAMPLE_LSB = 2;
  localparam int RGB_W      = 3 * SAMPLE_W;

  // configuration registers
  localparam int WIDTH_W = 10;
  localparam int ROWS_W  = 11;
  localparam int CFG_AW  = 1;
  localparam int CFG_DW  = 11;

  localparam logic [CFG_AW-1:0] REG_ROW_WIDTH  = 1'b0;
  localparam logic [CFG_AW-1:0] REG_FRAME_ROWS = 1'b1;

  localparam logic [WIDTH_W-1:0] RESET_ROW_WIDTH  = 10'd320;
  localparam logic [ROWS_W-1:0]  RESET_FRAME_ROWS = 11'd240;

  // where the current pixel sits in the mosaic
  typedef struct packed {
    logic               even_row;
    logic               odd_col;
    logic               result;
    logic               row_end;
    logic               frame_end;
    logic [BANK_AW-1:0] bank_addr;
  } pos_t;

endpackage

`default_nettype wire

// ===== src/brb_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/brb_pos.sv =====
// configuration registers and column / row position counters
`timescale 1ns / 1ps
`default_nettype none

module brb_pos (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [brb_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [brb_pkg::CFG_DW-1:0]  cfg_wdata,
  input  wire logic                        step,
  output brb_pkg::pos_t                    pos
);

  import brb_pkg::*;

  logic [WIDTH_W-1:0] row_width;
  logic [ROWS_W-1:0]  frame_rows;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;

  logic [COLC_W-1:0] w;
  logic [ROWC_W-1:0] h;
  logic [COL_W-1:0]  col_cur;
  logic [ROW_W-1:0]  row_cur;
  logic [COLC_W-1:0] col_inc;
  logic [ROWC_W-1:0] row_inc;
  logic [COLC_W-1:0] last_col;
  logic [ROWC_W-1:0] last_row;
  logic              col_wrap;
  logic              row_wrap;
  logic              row_end_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width  <= RESET_ROW_WIDTH;
      frame_rows <= RESET_FRAME_ROWS;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ROW_WIDTH:  row_width  <= cfg_wdata[WIDTH_W-1:0];
        REG_FRAME_ROWS: frame_rows <= cfg_wdata[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // sizes in use, clamped to what the counters and line store support
  always_comb begin
    if (row_width < WIDTH_W'(2)) begin
      w = COLC_W'(2);
    end else if (int'(row_width) > MAX_WIDTH) begin
      w = COLC_W'(MAX_WIDTH);
    end else begin
      w = COLC_W'(row_width);
    end
    if (frame_rows < ROWS_W'(2)) begin
      h = ROWC_W'(2);
    end else if (int'(frame_rows) > MAX_ROWS) begin
      h = ROWC_W'(MAX_ROWS);
    end else begin
      h = ROWC_W'(frame_rows);
    end
  end

  // a counter left past a shrunk size restarts at zero
  assign col_cur = ({1'b0, col} >= w) ? '0 : col;
  assign row_cur = ({1'b0, row} >= h) ? '0 : row;

  assign col_inc  = {1'b0, col_cur} + COLC_W'(1);
  assign row_inc  = {1'b0, row_cur} + ROWC_W'(1);
  assign col_wrap = col_inc >= w;
  assign row_wrap = row_inc >= h;

  // an odd final column or row gives no result
  assign last_col    = {w[COLC_W-1:1], 1'b0} - COLC_W'(1);
  assign last_row    = {h[ROWC_W-1:1], 1'b0} - ROWC_W'(1);
  assign row_end_hit = {1'b0, col_cur} == last_col;

  assign pos.even_row  = ~row_cur[0];
  assign pos.odd_col   = col_cur[0];
  assign pos.result    = row_cur[0] & col_cur[0];
  assign pos.row_end   = row_end_hit;
  assign pos.frame_end = row_end_hit && ({1'b0, row_cur} == last_row);
  assign pos.bank_addr = col_cur[COL_W-1:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (step) begin
      if (col_wrap) begin
        col <= '0;
        row <= row_wrap ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col <= col_inc[COL_W-1:0];
        row <= row_cur;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/brb_cell.sv =====
// cell stage and output register: assembles red, green, blue per 2x2 cell
`timescale 1ns / 1ps
`default_nettype none

module brb_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire brb_pkg::pos_t                 pos,
  input  wire logic [brb_pkg::SAMPLE_W-1:0]  sample,
  input  wire logic [brb_pkg::SAMPLE_W-1:0]  even_q,
  input  wire logic [brb_pkg::SAMPLE_W-1:0]  odd_q,
  output logic                               s1_free,
  input  wire logic                          m_tready,
  output logic                               m_tvalid,
  output logic      [brb_pkg::RGB_W-1:0]     m_tdata,
  output logic                               m_tlast,
  output logic                               m_tuser
);

  import brb_pkg::*;

  logic                held;
  logic [SAMPLE_W-1:0] held_left;
  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_left;
  logic [SAMPLE_W-1:0] s1_blue;
  logic                s1_row_end;
  logic                s1_frame_end;
  logic                out_free;
  logic [SAMPLE_W:0]   green_sum;

  assign held = step & ~pos.even_row & ~pos.odd_col;

  // lower-left sample of the cell being built
  always_ff @(posedge clk) begin
    if (rst) begin
      held_left <= '0;
    end else if (held) begin
      held_left <= sample;
    end
  end

  assign out_free = ~m_tvalid | m_tready;
  assign s1_free  = ~s1_valid | out_free;

  // line store read data lands alongside this stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= step & pos.result;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1_left      <= held_left;
      s1_blue      <= sample;
      s1_row_end   <= pos.row_end;
      s1_frame_end <= pos.frame_end;
    end
  end

  assign green_sum = {1'b0, odd_q} + {1'b0, s1_left};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      m_tdata <= {s1_blue, green_sum[SAMPLE_W:1], even_q};
      m_tlast <= s1_row_end;
      m_tuser <= s1_frame_end;
    end
  end

endmodule

`default_nettype wire

// ===== src/bayer_raw10_bin2x2_to_rgb.sv =====
// top level: rggb raw pixel stream in, 2x2 binned rgb stream out
`timescale 1ns / 1ps
`default_nettype none

// Takes one raw pixel beat per clock in raster order (bits 9..2 of each word
// are the sample) and gives one rgb beat per 2x2 rggb cell, at the cell's
// bottom-right pixel: red is top-left, green the floor mean of the two greens,
// blue bottom-right. An input beat is taken every cycle while the result side
// keeps up; after its bottom-right pixel is accepted, a result passes the cell
// stage, where the line store read data lands, and then the output register.
// Even-row samples sit in two 256 x 8 line store banks, one per column parity,
// so both top samples of a cell come out of the same read. The line store
// holds no reset value and needs no clearing pass; the block is ready right
// after reset. row_width and frame_rows are clamped to 2..512 and 2..1024; an
// odd last column or row gives no result. tlast marks the last beat of an
// output row, tuser the last beat of the frame. Write the configuration only
// while the block is idle.
module bayer_raw10_bin2x2_to_rgb (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [brb_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [brb_pkg::CFG_DW-1:0]  cfg_wdata,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [brb_pkg::PIXEL_W-1:0] s_tdata,   // pixel_word
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic      [brb_pkg::RGB_W-1:0]   m_tdata,   // red, green, blue
  output logic                             m_tlast,   // row_end
  output logic                             m_tuser    // frame_end
);

  import brb_pkg::*;

  pos_t                pos;
  logic                step;
  logic                s1_free;
  logic [SAMPLE_W-1:0] sample;
  logic [SAMPLE_W-1:0] even_q;
  logic [SAMPLE_W-1:0] odd_q;
  logic                even_we;
  logic                odd_we;

  assign s_tready = s1_free;
  assign step     = s_tvalid & s1_free;
  assign sample   = s_tdata[SAMPLE_LSB +: SAMPLE_W];
  assign even_we  = step & pos.even_row & ~pos.odd_col;
  assign odd_we   = step & pos.even_row & pos.odd_col;

  brb_pos u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .pos       (pos)
  );

  // even-column samples of the top row
  brb_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (BANK_DEPTH)
  ) u_even_bank (
    .clk   (clk),
    .we    (even_we),
    .waddr (pos.bank_addr),
    .wdata (sample),
    .re    (step),
    .raddr (pos.bank_addr),
    .rdata (even_q)
  );

  // odd-column samples of the top row
  brb_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (BANK_DEPTH)
  ) u_odd_bank (
    .clk   (clk),
    .we    (odd_we),
    .waddr (pos.bank_addr),
    .wdata (sample),
    .re    (step),
    .raddr (pos.bank_addr),
    .rdata (odd_q)
  );

  brb_cell u_cell (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .pos      (pos),
    .sample   (sample),
    .even_q   (even_q),
    .odd_q    (odd_q),
    .s1_free  (s1_free),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

// ===== bench/bayer_raw10_bin2x2_to_rgb_test.sv =====
// self-checking bench for the rggb 2x2 binning block: random pixel frames vs a cell predictor
`timescale 1ns / 1ps

module bayer_raw10_bin2x2_to_rgb_test;
  import brb_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_PIXELS = 190;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic                row_end;
    logic                frame_end;
  } rgb_beat_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr = REG_ROW_WIDTH;
  logic [CFG_DW-1:0]   cfg_wdata = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [PIXEL_W-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [RGB_W-1:0]    m_tdata;
  logic                m_tlast;
  logic                m_tuser;

  // pixel words waiting for the driver, rgb beats waiting for the DUT
  logic [PIXEL_W-1:0]  pixel_queue[$];
  rgb_beat_t           rgb_expected[$];

  // predictor copy of the block state and registers
  logic [SAMPLE_W-1:0] top_row [MAX_WIDTH];
  logic [SAMPLE_W-1:0] lower_left = '0;
  int unsigned         col_pos = 0;
  int unsigned         row_pos = 0;
  logic [WIDTH_W-1:0]  width_reg = RESET_ROW_WIDTH;
  logic [ROWS_W-1:0]   rows_reg = RESET_FRAME_ROWS;

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  pix_taken = 1'b0;
  bit  src_steady = 1'b0;
  bit  sink_steady = 1'b0;
  int  src_gap = 0;
  int  sink_stall = 0;

  bayer_raw10_bin2x2_to_rgb DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned used_width();
    if (width_reg < 2) return 2;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned used_height();
    if (rows_reg < 2) return 2;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return rows_reg;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int draw_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one raw pixel into the mosaic; an rgb beat is due at each bottom-right pixel
  task automatic bin_pixel(input logic [PIXEL_W-1:0] word);
    int unsigned         w;
    int unsigned         h;
    int unsigned         c;
    int unsigned         r;
    logic [SAMPLE_W:0]   green_sum;
    logic [SAMPLE_W-1:0] sample;
    rgb_beat_t           beat;
    w = used_width();
    h = used_height();
    sample = word[SAMPLE_LSB +: SAMPLE_W];
    // a shrunk size restarts a counter that now lies outside it
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    if (!r[0]) begin
      top_row[c] = sample;
    end else if (!c[0]) begin
      lower_left = sample;
    end else begin
      green_sum = top_row[c] + lower_left;
      beat.red = top_row[c - 1];
      beat.green = green_sum[SAMPLE_W:1];
      beat.blue = sample;
      // odd width or height: the trailing column or row never closes a cell
      beat.row_end = (c == (w & ~32'd1) - 1);
      beat.frame_end = beat.row_end && (r == (h & ~32'd1) - 1);
      rgb_expected.push_back(beat);
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  function automatic void check_field(input string name, input logic [SAMPLE_W-1:0] want,
                                      input logic [SAMPLE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // pixel source: a beat stays up until taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || pix_taken) begin
      if (src_gap > 0) begin
        s_tvalid <= 1'b0;
        src_gap = src_gap - 1;
      end else if (pixel_queue.size() != 0) begin
        s_tdata <= pixel_queue.pop_front();
        s_tvalid <= 1'b1;
        src_gap = src_steady ? 0 : draw_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // rgb sink with random back-pressure
  always @(negedge clk) begin
    if (sink_stall > 0) begin
      m_tready <= 1'b0;
      sink_stall = sink_stall - 1;
    end else begin
      m_tready <= 1'b1;
      if (!sink_steady) sink_stall = draw_gap();
    end
  end

  always @(posedge clk) begin
    rgb_beat_t got;
    rgb_beat_t want;
    pix_taken = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.red = m_tdata[0 +: SAMPLE_W];
        got.green = m_tdata[SAMPLE_W +: SAMPLE_W];
        got.blue = m_tdata[2*SAMPLE_W +: SAMPLE_W];
        got.row_end = m_tlast;
        got.frame_end = m_tuser;
        if (rgb_expected.size() == 0) begin
          $error("rgb beat %h with none expected", m_tdata);
          mismatches++;
        end else begin
          want = rgb_expected.pop_front();
          check_field("red", want.red, got.red);
          check_field("green", want.green, got.green);
          check_field("blue", want.blue, got.blue);
          check_field("row_end", want.row_end, got.row_end);
          check_field("frame_end", want.frame_end, got.frame_end);
        end
      end
      if (s_tvalid && s_tready) begin
        pix_taken = 1'b1;
        bin_pixel(s_tdata);
      end
      if ((m_tvalid && m_tready) || pix_taken || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ROW_WIDTH) width_reg = val[WIDTH_W-1:0];
    else rows_reg = val[ROWS_W-1:0];
  endtask

  // everything sent and every rgb beat back, then the pipeline is left to drain
  task automatic wait_idle();
    while (pixel_queue.size() != 0 || s_tvalid || rgb_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic stream_pixels(input int count);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 15))
        0: pixel_queue.push_back(16'hFFFF);
        1: pixel_queue.push_back(16'h0000);
        default: pixel_queue.push_back(PIXEL_W'($urandom));
      endcase
    end
    wait_idle();
  endtask

  initial begin
    int unsigned width_picks [7];
    int unsigned rows_picks [7];
    int          random_pixels;
    int          n;
    width_picks = '{0, 1, 2, 511, 512, 513, 1023};
    rows_picks = '{0, 1, 2, 1023, 1024, 1025, 2047};
    random_pixels = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // one row pair at the reset geometry
    stream_pixels(640);

    // single-cell frames: all ones, all zeros, green rounding down, bit patterns
    write_reg(REG_ROW_WIDTH, 11'd2);
    write_reg(REG_FRAME_ROWS, 11'd2);
    pixel_queue = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'h0000, 16'h0000, 16'h0000, 16'h0000,
                   16'hFC00, 16'h0007, 16'h0008, 16'h03FC,
                   16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA};
    wait_idle();

    // odd width and height: trailing column and row give nothing
    write_reg(REG_ROW_WIDTH, 11'd3);
    write_reg(REG_FRAME_ROWS, 11'd3);
    pixel_queue = {16'h0004, 16'h0008, 16'h000C, 16'h0010, 16'h0014,
                   16'h0018, 16'h001C, 16'h0020, 16'h0024};
    wait_idle();

    while (random_pixels < RANDOM_PIXELS) begin
      // sizes change only on an even row, so every odd row reads a top row
      // written at its own width
      if (!row_pos[0]) begin
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 9))
            0: write_reg(REG_ROW_WIDTH, CFG_DW'(width_picks[$urandom_range(0, 6)]));
            1: write_reg(REG_ROW_WIDTH, CFG_DW'($urandom_range(0, 2047)));
            default: write_reg(REG_ROW_WIDTH, CFG_DW'($urandom_range(2, 16)));
          endcase
        end
        if ($urandom_range(0, 3) != 0) begin
          if ($urandom_range(0, 7) == 0)
            write_reg(REG_FRAME_ROWS, CFG_DW'(rows_picks[$urandom_range(0, 6)]));
          else
            write_reg(REG_FRAME_ROWS, CFG_DW'($urandom_range(2, 9)));
        end
      end
      // whole frames when small, otherwise a slice that stops mid-frame
      n = used_width() * used_height() * $urandom_range(1, 2);
      if (n > 48) n = $urandom_range(8, 48);
      if (n > RANDOM_PIXELS - random_pixels) n = RANDOM_PIXELS - random_pixels;
      src_steady = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 4) == 0);
      stream_pixels(n);
      random_pixels += n;
    end

    if (mismatches == 0 && rgb_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
